[sv/phcal_pkg.sv]
// Package for the pH two-point calibrator: widths, step codes, constants.
// No dependencies.
`default_nettype none
package phcal_pkg;
  localparam int SampleBits = 12;
  localparam int FracBits   = 16;
  localparam int SlopeW     = 32;
  localparam int OffsW      = 40;
  localparam int AccW       = 48;

  localparam logic [3:0] StepStart7  = 4'd0;
  localparam logic [3:0] StepProbe7  = 4'd1;
  localparam logic [3:0] StepSave7   = 4'd2;
  localparam logic [3:0] StepStart4  = 4'd3;
  localparam logic [3:0] StepProbe4  = 4'd4;
  localparam logic [3:0] StepSave4   = 4'd5;
  localparam logic [3:0] StepCalc    = 4'd6;
  localparam logic [3:0] StepVerify  = 4'd7;
  localparam logic [3:0] StepStore   = 4'd8;

  localparam logic [1:0] RegWindow   = 2'd0;
  localparam logic [1:0] RegWait     = 2'd1;
  localparam logic [1:0] RegProgress = 2'd2;

  localparam int BtnA = 4;
  localparam int BtnB = 5;

  typedef struct packed {
    logic [2:0]  indicator;
    logic        stable;
  } stab_status_t;
endpackage
`default_nettype wire

[sv/phcal_if.sv]
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
`default_nettype none
interface phcal_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/phcal_alu.sv]
// Shared serial unit: shift-add multiply and restoring divide, one bit per cycle.
// Uses phcal_pkg.
`default_nettype none
module phcal_alu import phcal_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             div_i,
  input  wire logic [OffsW-1:0] a_i,
  input  wire logic [15:0]      b_i,
  output logic                  done_o,
  output logic [AccW-1:0]       res_o
);
  // Multiply: res = a * b (a signed, b unsigned 16 bit), 16 steps.
  // Divide: a / b (unsigned, 24 bit dividend), 24 steps; the quotient sits in
  // res[23:0] and the remainder in res[39:24].
  logic             busy_q, busy_d, div_q, div_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [AccW-1:0]  acc_q, acc_d, mc_q, mc_d;
  logic [15:0]      mp_q, mp_d;
  logic [23:0]      quo_q, quo_d;
  logic [16:0]      rem_q, rem_d;
  logic [16:0]      trial;

  always_comb begin
    busy_d = busy_q; div_d = div_q; cnt_d = cnt_q;
    acc_d = acc_q; mc_d = mc_q; mp_d = mp_q; quo_d = quo_q; rem_d = rem_q;
    trial = {rem_q[15:0], quo_q[23]} - {1'b0, mp_q};
    if (start_i) begin
      busy_d = 1'b1; div_d = div_i; cnt_d = '0;
      acc_d = '0; mc_d = {{(AccW-OffsW){a_i[OffsW-1]}}, a_i}; mp_d = b_i;
      quo_d = a_i[23:0]; rem_d = '0;
    end else if (busy_q) begin
      if (div_q) begin
        if (!trial[16]) begin
          rem_d = trial; quo_d = {quo_q[22:0], 1'b1};
        end else begin
          rem_d = {rem_q[15:0], quo_q[23]}; quo_d = {quo_q[22:0], 1'b0};
        end
        if (cnt_q == 5'd23) busy_d = 1'b0;
      end else begin
        if (mp_q[0]) acc_d = acc_q + mc_q;
        mc_d = {mc_q[AccW-2:0], 1'b0};
        mp_d = {1'b0, mp_q[15:1]};
        if (cnt_q == 5'd15) busy_d = 1'b0;
      end
      cnt_d = cnt_q + 5'd1;
    end
  end

  assign res_o = div_q ? {{(AccW-40){1'b0}}, rem_q[15:0], quo_q} : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; div_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; div_q <= div_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; mp_q <= mp_d; quo_q <= quo_d; rem_q <= rem_d;
  end

  logic busy_dly_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_dly_q <= 1'b0;
    else         busy_dly_q <= busy_q;
  end
  // Done pulses for one cycle once the last step has been registered.
  assign done_o = busy_dly_q & ~busy_q;
endmodule
`default_nettype wire

[sv/phcal_stab.sv]
// Stability detector, button release detect and the count behind the progress indicator.
// Uses phcal_pkg.
`default_nettype none
module phcal_stab import phcal_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  upd_i,
  input  wire logic                  clr_i,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic [5:0]            pins_i,
  input  wire logic [7:0]            window_i,
  input  wire logic [15:0]           wait_i,
  output logic [5:0]                 events_o,
  output logic                       stable_o,
  output logic [15:0]                count_o
);
  logic [SampleBits-1:0] centre_q;
  logic [15:0]           count_q;
  logic                  stable_q;
  logic [5:0]            prev_q;
  logic [SampleBits-1:0] diff;

  assign diff = (centre_q > sample_i) ? centre_q - sample_i : sample_i - centre_q;
  assign events_o = prev_q & pins_i;
  assign stable_o = stable_q;
  assign count_o  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0; count_q <= '0; stable_q <= 1'b0; prev_q <= '0;
    end else if (upd_i) begin
      prev_q <= ~pins_i;
      if ({{(16-SampleBits){1'b0}}, diff} < {8'd0, window_i}) begin
        if (count_q > wait_i) begin
          stable_q <= 1'b1; count_q <= '0; centre_q <= sample_i;
        end else begin
          count_q <= count_q + 16'd1;
        end
      end else begin
        stable_q <= 1'b0; count_q <= '0; centre_q <= sample_i;
      end
    end else if (clr_i) begin
      count_q <= '0; stable_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[sv/ph_two_point_calibrator.sv]
// pH two-point calibrator top level.
// Per item: stability update and indicator search, then a 16-step serial multiply in normal
// mode and the verify step, a 24-step divide then a multiply in the calculate step when the
// readings differ, and no arithmetic otherwise. One item at a time: the result waits in an
// output register, the next item is taken only once it is gone.
// Asynchronous active-low reset: normal mode, step 0, stable detector cleared, saved line zero.
`default_nettype none
module ph_two_point_calibrator import phcal_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  phcal_if.sink            in_if,
  phcal_if.source          out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  // Sequencer states.
  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SStab   = 4'd1;
  localparam logic [3:0] SLevel  = 4'd2;
  localparam logic [3:0] SMulGo  = 4'd3;
  localparam logic [3:0] SMulRun = 4'd4;
  localparam logic [3:0] SDivGo  = 4'd5;
  localparam logic [3:0] SDivRun = 4'd6;
  localparam logic [3:0] SOffGo  = 4'd7;
  localparam logic [3:0] SOffRun = 4'd8;
  localparam logic [3:0] SOut    = 4'd9;
  localparam logic [3:0] SLvlRun = 4'd10;

  logic [3:0]  st_q, st_d;
  logic [7:0]  window_q;
  logic [15:0] wait_q;
  logic [13:0] prog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 8'd4; wait_q <= 16'd300; prog_q <= 14'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWindow:   window_q <= cfg_data_i[7:0];
        RegWait:     wait_q   <= cfg_data_i;
        RegProgress: prog_q   <= cfg_data_i[13:0];
        default:     ;
      endcase
    end
  end

  // Latched input item.
  logic [SampleBits-1:0] smp_q;
  logic [5:0]            pins_q;

  // Stability detector.
  logic [5:0]  events;
  logic        stab, stab_upd, stab_clr;
  logic [15:0] count;
  phcal_stab u_stab (
    .clk_i, .rst_ni, .upd_i(stab_upd), .clr_i(stab_clr),
    .sample_i(smp_q), .pins_i(pins_q), .window_i(window_q), .wait_i(wait_q),
    .events_o(events), .stable_o(stab), .count_o(count)
  );

  // Calibration state.
  logic        mode_q;
  logic [3:0]  step_q;
  logic [SampleBits-1:0] neu_q, acid_q;
  logic signed [SlopeW-1:0] tsl_q, ssl_q;
  logic signed [OffsW-1:0]  tof_q, sof_q;
  logic [5:0]  ev_q;
  logic        mul_trial_q;

  // Indicator: level found by repeated subtraction, at most five steps.
  logic [15:0] rem_q;
  logic [2:0]  lvl_q;
  stab_status_t stat_q;

  // Shared arithmetic unit.
  logic             alu_start, alu_div;
  logic [OffsW-1:0] alu_a;
  logic [15:0]      alu_b;
  logic             alu_done;
  logic [AccW-1:0]  alu_res;
  logic [5:0]       wcnt_q;
  phcal_alu u_alu (
    .clk_i, .rst_ni, .start_i(alu_start), .div_i(alu_div), .a_i(alu_a),
    .b_i(alu_b), .done_o(alu_done), .res_o(alu_res)
  );

  // Difference of the two readings and its sign.
  logic        acid_gt;
  logic [SampleBits-1:0] dmag;
  assign acid_gt = acid_q > neu_q;
  assign dmag = acid_gt ? acid_q - neu_q : neu_q - acid_q;

  // Result fields.
  logic signed [15:0] ph_q;
  logic        vld_q, err_q, ovalid_q;

  // pH from accumulator: floor shift by FracBits-8 then saturate.
  logic signed [AccW-1:0] acc_sum, acc_sh;
  logic signed [AccW-1:0] offs_sel;
  assign offs_sel = mul_trial_q ? {{(AccW-OffsW){tof_q[OffsW-1]}}, tof_q}
                                : {{(AccW-OffsW){sof_q[OffsW-1]}}, sof_q};
  assign acc_sum = offs_sel + $signed(alu_res);
  assign acc_sh  = acc_sum >>> (FracBits-8);
  logic signed [15:0] ph_sat;
  always_comb begin
    if (acc_sh > 48'sd32767)       ph_sat = 16'sh7fff;
    else if (acc_sh < -48'sd32768) ph_sat = 16'sh8000;
    else                           ph_sat = acc_sh[15:0];
  end

  // Slope from quotient: floor(-3*2^F/d) for acid>neutral is -ceil(n/d).
  logic [23:0] quo;
  logic        rem_nz;
  assign quo = alu_res[23:0];
  logic signed [SlopeW-1:0] slope_new;
  assign rem_nz = |alu_res[39:24];
  assign slope_new = acid_gt ? -$signed({8'd0, quo + {23'd0, rem_nz}})
                             : $signed({8'd0, quo});

  assign in_if.ready  = (st_q == SIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = {ph_q, vld_q, mode_q, step_q, stat_q.indicator, stat_q.stable,
                         err_q};

  always_comb begin
    st_d = st_q;
    alu_start = 1'b0; alu_div = 1'b0; alu_a = '0; alu_b = '0;
    stab_upd = 1'b0;
    case (st_q)
      SIdle:   if (in_if.valid && in_if.ready) st_d = SStab;
      SStab:   begin stab_upd = 1'b1; st_d = SLevel; end
      SLevel:  st_d = SLvlRun;
      SLvlRun: if (stat_q.stable || prog_q == 14'd0 || rem_q < {2'd0, prog_q}
                   || lvl_q == 3'd5) st_d = SMulGo;
      SMulGo: begin
        if (!mode_q || step_q == StepVerify) begin
          alu_start = 1'b1;
          alu_a = mul_trial_q ? {{(OffsW-SlopeW){tsl_q[SlopeW-1]}}, tsl_q}
                              : {{(OffsW-SlopeW){ssl_q[SlopeW-1]}}, ssl_q};
          alu_b = {{(16-SampleBits){1'b0}}, smp_q};
          st_d = SMulRun;
        end else if (step_q == StepCalc && acid_q != neu_q) begin
          st_d = SDivGo;
        end else st_d = SOut;
      end
      SMulRun: if (wcnt_q == 6'd17) st_d = SOut;
      SDivGo: begin
        alu_start = 1'b1; alu_div = 1'b1;
        alu_a = OffsW'(3 << FracBits);
        alu_b = {{(16-SampleBits){1'b0}}, dmag};
        st_d = SDivRun;
      end
      SDivRun: if (wcnt_q == 6'd25) st_d = SOffGo;
      SOffGo: begin
        alu_start = 1'b1;
        alu_a = {{(OffsW-SlopeW){tsl_q[SlopeW-1]}}, tsl_q};
        alu_b = {{(16-SampleBits){1'b0}}, neu_q};
        st_d = SOffRun;
      end
      SOffRun: if (wcnt_q == 6'd17) st_d = SOut;
      SOut:    st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  logic unused;
  assign unused = alu_done ^ ^count[15:0] ^ ^ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; mode_q <= 1'b0; step_q <= StepStart7; ovalid_q <= 1'b0;
      ssl_q <= '0; sof_q <= '0; wcnt_q <= '0; mul_trial_q <= 1'b0;
      stat_q <= '0; rem_q <= '0; lvl_q <= '0; ev_q <= '0;
      ph_q <= '0; vld_q <= 1'b0; err_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      wcnt_q <= (st_q == st_d) ? wcnt_q + 6'd1 : '0;
      case (st_q)
        SIdle: if (in_if.valid && in_if.ready) begin
          smp_q  <= in_if.data[17:6];
          pins_q <= in_if.data[5:0];
          mul_trial_q <= mode_q;
        end
        SStab: ev_q <= events;
        SLevel: begin
          stat_q.stable <= stab; rem_q <= count; lvl_q <= '0;
        end
        SLvlRun: begin
          if (stat_q.stable) stat_q.indicator <= 3'd5;
          else if (prog_q == 14'd0 || lvl_q == 3'd5) stat_q.indicator <= 3'd6;
          else if (rem_q < {2'd0, prog_q}) stat_q.indicator <= lvl_q;
          else begin
            rem_q <= rem_q - {2'd0, prog_q}; lvl_q <= lvl_q + 3'd1;
          end
        end
        SDivRun: if (wcnt_q == 6'd25) tsl_q <= slope_new;
        SOffRun: if (wcnt_q == 6'd17)
          tof_q <= OffsW'(7 << FracBits) - OffsW'($signed(alu_res));
        SOut: begin
          ovalid_q <= 1'b1;
          err_q <= 1'b0; vld_q <= 1'b0; ph_q <= '0;
          if (!mode_q) begin
            vld_q <= 1'b1; ph_q <= ph_sat;
            if (ev_q[BtnA]) mode_q <= 1'b1;
          end else begin
            case (step_q)
              StepProbe7, StepProbe4: if (stat_q.stable) step_q <= step_q + 4'd1;
              StepSave7: begin neu_q <= smp_q; step_q <= StepStart4; end
              StepStart4: if (ev_q[BtnA]) step_q <= StepProbe4;
              StepSave4: begin acid_q <= smp_q; step_q <= StepCalc; end
              StepCalc: begin
                if (acid_q == neu_q) begin
                  err_q <= 1'b1; step_q <= StepStart7; mode_q <= 1'b0;
                end else step_q <= StepVerify;
              end
              StepVerify: begin
                vld_q <= 1'b1; ph_q <= ph_sat;
                if (ev_q[BtnA]) step_q <= StepStore;
              end
              StepStore: begin
                ssl_q <= tsl_q; sof_q <= tof_q;
                step_q <= StepStart7; mode_q <= 1'b0;
              end
              default: step_q <= ev_q[BtnA] ? StepProbe7 : StepStart7;
            endcase
            if (ev_q[BtnB]) begin step_q <= StepStart7; mode_q <= 1'b0; end
          end
        end
        default: ;
      endcase
    end
  end

  // In calibration mode, start steps and step codes above the store step clear the detector before the next tick.
  assign stab_clr = (st_q == SOut) && mode_q &&
                    (step_q == StepStart4 || step_q == StepStart7 || step_q > StepStore);
endmodule
`default_nettype wire
